// File: src/hpm_pkg.sv
// Shared types, register indexes and status codes for the homography point mapper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package hpm_pkg;

	localparam int PIXEL_BITS_DEF = 12;
	localparam int IN_PIX_W = PIXEL_BITS_DEF;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;
	localparam logic [30:0] FLOOR_RESET = 31'd1074;

	localparam logic [CFG_IDX_W-1:0] REG_H00_H01 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_H02_H10 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_H11_H12 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_H20_H21 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_H22 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FLOOR = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CAL = 3'd6;

	localparam logic [1:0] ST_VALID = 2'd0;
	localparam logic [1:0] ST_DEGEN = 2'd1;
	localparam logic [1:0] ST_UNCAL = 2'd2;

	typedef struct packed {
		logic [IN_PIX_W-1:0] pixel_u;
		logic [IN_PIX_W-1:0] pixel_v;
		logic polygon_end;
	} hpm_in_t;

	typedef struct packed {
		logic signed [31:0] world_x;
		logic signed [31:0] world_y;
		logic [1:0] point_status;
		logic polygon_end_out;
	} hpm_out_t;

	typedef struct packed {
		logic signed [31:0] h00;
		logic signed [31:0] h01;
		logic signed [31:0] h02;
		logic signed [31:0] h10;
		logic signed [31:0] h11;
		logic signed [31:0] h12;
		logic signed [31:0] h20;
		logic signed [31:0] h21;
		logic signed [31:0] h22;
		logic [30:0] floor_val;
		logic cal;
	} hpm_cfg_t;

endpackage
`default_nettype wire

// File: src/hpm_front.sv
// Front stages: coefficient products, row sums, magnitudes and point status.
// Depends on hpm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hpm_front
	import hpm_pkg::*;
#(
	parameter int SW = IN_PIX_W + 48
) (
	input  wire logic clk,
	input  wire logic en,
	input  wire hpm_cfg_t cfg,
	input  wire logic [IN_PIX_W-1:0] pixel_u,
	input  wire logic [IN_PIX_W-1:0] pixel_v,
	output logic [SW-1:0] mag_x,
	output logic [SW-1:0] mag_y,
	output logic [SW-1:0] mag_w,
	output logic neg_x,
	output logic neg_y,
	output logic [1:0] status
);
	localparam int PW = IN_PIX_W + 33;

	logic signed [IN_PIX_W:0] us, vs;
	logic signed [PW-1:0] p00_s1, p01_s1, p10_s1, p11_s1, p20_s1, p21_s1;
	logic signed [SW-1:0] nx_s2, ny_s2, w_s2;
	logic signed [SW-1:0] fl;

	assign us = $signed({1'b0, pixel_u});
	assign vs = $signed({1'b0, pixel_v});
	assign fl = SW'($signed({1'b0, cfg.floor_val}));

	always_ff @(posedge clk) begin
		if (en) begin
			p00_s1 <= cfg.h00 * us;
			p01_s1 <= cfg.h01 * vs;
			p10_s1 <= cfg.h10 * us;
			p11_s1 <= cfg.h11 * vs;
			p20_s1 <= cfg.h20 * us;
			p21_s1 <= cfg.h21 * vs;
			nx_s2 <= SW'(p00_s1) + SW'(p01_s1) + SW'(cfg.h02);
			ny_s2 <= SW'(p10_s1) + SW'(p11_s1) + SW'(cfg.h12);
			w_s2 <= SW'(p20_s1) + SW'(p21_s1) + (SW'(cfg.h22) <<< 14);
			mag_x <= nx_s2[SW-1] ? SW'(-nx_s2) : nx_s2;
			mag_y <= ny_s2[SW-1] ? SW'(-ny_s2) : ny_s2;
			mag_w <= w_s2[SW-1] ? SW'(-w_s2) : w_s2;
			neg_x <= nx_s2[SW-1] ^ w_s2[SW-1];
			neg_y <= ny_s2[SW-1] ^ w_s2[SW-1];
			if (!cfg.cal) begin
				status <= ST_UNCAL;
			end else if ((w_s2 <= fl) && (w_s2 >= -fl)) begin
				status <= ST_DEGEN;
			end else begin
				status <= ST_VALID;
			end
		end
	end
endmodule
`default_nettype wire

// File: src/hpm_divider.sv
// Pipelined restoring divider: round(mag * 163840 / den), rounded half away from zero,
// signed and saturated to 32 bits. One quotient bit per stage. Depends on hpm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hpm_divider
	import hpm_pkg::*;
#(
	parameter int MW = 60
) (
	input  wire logic clk,
	input  wire logic en,
	input  wire logic [MW-1:0] mag,
	input  wire logic [MW-1:0] den,
	input  wire logic neg,
	output logic signed [31:0] q
);
	localparam int DW = MW + 18;
	localparam int QB = 33;

	logic [DW-1:0] dvd_d0;
	logic [MW-1:0] den_d0;
	logic neg_d0;

	logic [MW-1:0] rem_st [0:QB];
	logic [QB-1:0] low_st [0:QB];
	logic [QB-1:0] quo_st [0:QB];
	logic [MW-1:0] den_st [0:QB];
	logic neg_st [0:QB];
	logic big_st [0:QB];

	logic [33:0] mag_r;
	logic neg_r;

	always_ff @(posedge clk) begin
		if (en) begin
			dvd_d0 <= (DW'(mag) << 17) + (DW'(mag) << 15);
			den_d0 <= den;
			neg_d0 <= neg;

			rem_st[0] <= MW'(dvd_d0[DW-1:QB]);
			low_st[0] <= dvd_d0[QB-1:0];
			quo_st[0] <= '0;
			den_st[0] <= den_d0;
			neg_st[0] <= neg_d0;
			big_st[0] <= MW'(dvd_d0[DW-1:QB]) >= den_d0;

			for (int k = 0; k < QB; k++) begin
				if ({rem_st[k], low_st[k][QB-1]} >= {1'b0, den_st[k]}) begin
					rem_st[k+1] <= MW'({rem_st[k], low_st[k][QB-1]} - {1'b0, den_st[k]});
					quo_st[k+1] <= {quo_st[k][QB-2:0], 1'b1};
				end else begin
					rem_st[k+1] <= {rem_st[k][MW-2:0], low_st[k][QB-1]};
					quo_st[k+1] <= {quo_st[k][QB-2:0], 1'b0};
				end
				low_st[k+1] <= {low_st[k][QB-2:0], 1'b0};
				den_st[k+1] <= den_st[k];
				neg_st[k+1] <= neg_st[k];
				big_st[k+1] <= big_st[k];
			end

			if (big_st[QB]) begin
				mag_r <= 34'h1_0000_0000;
			end else if ({rem_st[QB], 1'b0} >= {1'b0, den_st[QB]}) begin
				mag_r <= 34'(quo_st[QB]) + 34'd1;
			end else begin
				mag_r <= 34'(quo_st[QB]);
			end
			neg_r <= neg_st[QB];

			if (neg_r) begin
				q <= (mag_r >= 34'h0_8000_0000) ? 32'sh8000_0000 : 32'(34'd0 - mag_r);
			end else begin
				q <= (mag_r > 34'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : mag_r[31:0];
			end
		end
	end
endmodule
`default_nettype wire

// File: src/homography_point_map.sv
// Top level of the homography point mapper: configuration registers, handshake
// pipeline control and output assembly. Depends on hpm_pkg, hpm_front, hpm_divider.
// One point per clock while the output is not stalled; three front stages of products,
// sums and magnitudes, then one scaling stage, one range check, 33 quotient-bit stages,
// a rounding stage and a saturating output register. A stalled output holds the whole
// pipeline. Write configuration only while no point is in flight.
`timescale 1ns / 1ps
`default_nettype none
module homography_point_map
	import hpm_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire hpm_in_t in_data,
	output logic out_valid,
	input  wire logic out_ready,
	output hpm_out_t out_data,
	input  wire logic cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);
	localparam int SW = IN_PIX_W + 48;
	localparam int FRONT_LAT = 3;
	localparam int DIV_LAT = 37;
	localparam int LAT = FRONT_LAT + DIV_LAT;

	hpm_cfg_t cfg_q;
	logic en;
	logic [LAT-1:0] vld_q;
	logic pend_q [0:LAT-1];
	logic [1:0] st_q [0:DIV_LAT-1];
	logic [SW-1:0] mag_x, mag_y, mag_w;
	logic neg_x, neg_y;
	logic [1:0] status;
	logic signed [31:0] qx, qy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= {{9{32'd0}}, FLOOR_RESET, 1'b0};
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_H00_H01: begin
					cfg_q.h00 <= cfg_data[63:32];
					cfg_q.h01 <= cfg_data[31:0];
				end
				REG_H02_H10: begin
					cfg_q.h02 <= cfg_data[63:32];
					cfg_q.h10 <= cfg_data[31:0];
				end
				REG_H11_H12: begin
					cfg_q.h11 <= cfg_data[63:32];
					cfg_q.h12 <= cfg_data[31:0];
				end
				REG_H20_H21: begin
					cfg_q.h20 <= cfg_data[63:32];
					cfg_q.h21 <= cfg_data[31:0];
				end
				REG_H22: cfg_q.h22 <= cfg_data[31:0];
				REG_FLOOR: cfg_q.floor_val <= cfg_data[30:0];
				REG_CAL: cfg_q.cal <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign en = !vld_q[LAT-1] || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pend_q[0] <= in_data.polygon_end;
			for (int k = 1; k < LAT; k++) begin
				pend_q[k] <= pend_q[k-1];
			end
			st_q[0] <= status;
			for (int k = 1; k < DIV_LAT; k++) begin
				st_q[k] <= st_q[k-1];
			end
		end
	end

	hpm_front #(.SW(SW)) u_front (
		.clk(clk),
		.en(en),
		.cfg(cfg_q),
		.pixel_u(in_data.pixel_u),
		.pixel_v(in_data.pixel_v),
		.mag_x(mag_x),
		.mag_y(mag_y),
		.mag_w(mag_w),
		.neg_x(neg_x),
		.neg_y(neg_y),
		.status(status)
	);

	hpm_divider #(.MW(SW)) u_div_x (
		.clk(clk), .en(en), .mag(mag_x), .den(mag_w), .neg(neg_x), .q(qx)
	);

	hpm_divider #(.MW(SW)) u_div_y (
		.clk(clk), .en(en), .mag(mag_y), .den(mag_w), .neg(neg_y), .q(qy)
	);

	assign out_valid = vld_q[LAT-1];
	assign out_data.world_x = (st_q[DIV_LAT-1] == ST_VALID) ? qx : 32'sd0;
	assign out_data.world_y = (st_q[DIV_LAT-1] == ST_VALID) ? qy : 32'sd0;
	assign out_data.point_status = st_q[DIV_LAT-1];
	assign out_data.polygon_end_out = pend_q[LAT-1];

	a_zero_when_rejected: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.point_status != ST_VALID)
		|-> (out_data.world_x == 32'sd0) && (out_data.world_y == 32'sd0))
		else $error("rejected point carries coordinates");

	a_transfer_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_q[0])
		else $error("input transfer lost at pipeline entry");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.point_status == ST_VALID)
		|| (out_data.point_status == ST_DEGEN) || (out_data.point_status == ST_UNCAL))
		else $error("undefined point status");

	a_stall_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline advanced during stall");
endmodule
`default_nettype wire
